/* rtl/fqmtf_pkg.sv */
// Package: shared defaults, request codes and status codes for the move-to-front queue.
`default_nettype none

package fqmtf_pkg;

  // Default geometry
  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  // Request codes (code 3 is unused and answered as a no-op)
  localparam logic [1:0] ACT_ENQ = 2'd0;
  localparam logic [1:0] ACT_DEQ = 2'd1;
  localparam logic [1:0] ACT_MTF = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

endpackage

`default_nettype wire

/* rtl/fifo_queue_move_to_front.sv */
// Top level: bounded circular-buffer queue in one memory, with enqueue, dequeue and move-to-front.
// Enqueue, full, empty and unused codes, a dequeue that empties the queue and move-to-front on
// fewer than two entries are answered from idle; a dequeue that leaves entries behind first reads
// the new front entry; move-to-front does one memory read per scanned entry from the second on,
// and on a hit then one read-write per shifted entry, then the front write.
// One request is in flight at a time; the next is taken once the result slot frees.
// Reset clears the entry count, head pointer and control state; the memory is not cleared.
`default_nettype none

module fifo_queue_move_to_front #(
  parameter int DEPTH      = fqmtf_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = fqmtf_pkg::DATA_W_DEF,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_action,
  input  wire logic [DATA_WIDTH-1:0] in_item_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DATA_WIDTH-1:0]      out_front_value,
  output logic                       out_queue_empty,
  output logic [CNT_W-1:0]           out_entry_count,
  output logic [1:0]                 out_status
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);
  localparam logic [AW:0]      DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0]    POS_ONE = AW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ_WAIT,
    S_SCAN,
    S_SHIFT,
    S_FRONT_WR
  } state_t;

  // Map a queue position to a memory address, wrapping at DEPTH
  function automatic logic [AW-1:0] pos2addr(input logic [AW-1:0] head,
                                             input logic [AW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  state_t                state_r, state_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] front_r, front_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_front_r, out_front_nxt;
  logic                  out_empty_r, out_empty_nxt;
  logic [CNT_W-1:0]      out_count_r, out_count_nxt;
  logic [1:0]            out_status_r, out_status_nxt;

  logic                  in_accept;
  logic                  resp;
  fqmtf_pkg::status_t    resp_status;
  logic [AW-1:0]         pos_dec;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rdata_r;

  // Take a request only when idle and the result slot is free or draining
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_accept = in_valid && in_ready;
  assign pos_dec   = pos_r - POS_ONE;

  // Next-state and memory access logic
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    front_nxt     = front_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_front_nxt = out_front_r;
    out_empty_nxt = out_empty_r;
    out_count_nxt = out_count_r;
    out_status_nxt = out_status_r;
    resp          = 1'b0;
    resp_status   = fqmtf_pkg::ST_DONE;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          val_nxt = in_item_value;
          case (in_action)
            fqmtf_pkg::ACT_ENQ: begin
              resp = 1'b1;
              if (count_r == CNT_MAX) begin
                resp_status = fqmtf_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = pos2addr(head_r, count_r[AW-1:0]);
                wr_data   = in_item_value;
                count_nxt = count_r + CNT_W'(1);
                if (count_r == '0) begin
                  front_nxt = in_item_value;
                end
              end
            end
            fqmtf_pkg::ACT_DEQ: begin
              if (count_r == '0) begin
                resp        = 1'b1;
                resp_status = fqmtf_pkg::ST_EMPTY;
              end else begin
                head_nxt  = pos2addr(head_r, POS_ONE);
                count_nxt = count_r - CNT_W'(1);
                if (count_r == CNT_W'(1)) begin
                  resp = 1'b1;
                end else begin
                  // Fetch the new front entry
                  rd_en     = 1'b1;
                  rd_addr   = pos2addr(head_r, POS_ONE);
                  state_nxt = S_DEQ_WAIT;
                end
              end
            end
            fqmtf_pkg::ACT_MTF: begin
              if (count_r < CNT_W'(2)) begin
                resp        = 1'b1;
                resp_status = fqmtf_pkg::ST_NOMATCH;
              end else begin
                // Start the search at the second entry
                rd_en     = 1'b1;
                rd_addr   = pos2addr(head_r, POS_ONE);
                pos_nxt   = POS_ONE;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              resp = 1'b1;
            end
          endcase
        end
      end

      S_DEQ_WAIT: begin
        front_nxt = rdata_r;
        resp      = 1'b1;
        state_nxt = S_IDLE;
      end

      S_SCAN: begin
        if (rdata_r == val_r) begin
          // Hit: shift the entries ahead of it back by one, nearest first
          rd_en     = 1'b1;
          rd_addr   = pos2addr(head_r, pos_dec);
          state_nxt = S_SHIFT;
        end else if (CNT_W'(pos_r) + CNT_W'(1) < count_r) begin
          rd_en   = 1'b1;
          rd_addr = pos2addr(head_r, pos_r + POS_ONE);
          pos_nxt = pos_r + POS_ONE;
        end else begin
          resp        = 1'b1;
          resp_status = fqmtf_pkg::ST_NOMATCH;
          state_nxt   = S_IDLE;
        end
      end

      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = pos2addr(head_r, pos_r);
        wr_data = rdata_r;
        if (pos_r == POS_ONE) begin
          state_nxt = S_FRONT_WR;
        end else begin
          rd_en   = 1'b1;
          rd_addr = pos2addr(head_r, pos_dec - POS_ONE);
          pos_nxt = pos_dec;
        end
      end

      S_FRONT_WR: begin
        wr_en     = 1'b1;
        wr_addr   = head_r;
        wr_data   = val_r;
        front_nxt = val_r;
        resp      = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Load the result slot from the queue state after the action
    if (resp) begin
      out_valid_nxt  = 1'b1;
      out_count_nxt  = count_nxt;
      out_empty_nxt  = (count_nxt == '0);
      out_front_nxt  = (count_nxt == '0) ? '0 : front_nxt;
      out_status_nxt = resp_status;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    front_r      <= front_nxt;
    val_r        <= val_nxt;
    out_front_r  <= out_front_nxt;
    out_empty_r  <= out_empty_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = out_front_r;
  assign out_queue_empty = out_empty_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

  // Count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("entry count exceeds capacity");

  // Empty flag agrees with the reported count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_count_r == '0)))
    else $error("empty flag disagrees with entry count");

  // A successful enqueue grows the queue by one
  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_action == fqmtf_pkg::ACT_ENQ) && (count_r != CNT_MAX))
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("enqueue did not advance the count");

  // Search and shift never change the count or head
  a_mtf_stable: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) || (state_r == S_SHIFT) || (state_r == S_FRONT_WR))
      |=> ($stable(count_r) && $stable(head_r)))
    else $error("move-to-front changed count or head");

  // A result is produced only when the slot was free or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (resp && out_valid_r) |-> out_ready)
    else $error("result overwrote an untaken transaction");

endmodule

`default_nettype wire
